[hdl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the round-robin thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

	localparam logic [2:0] ACT_TICK      = 3'd0;
	localparam logic [2:0] ACT_SPAWN     = 3'd1;
	localparam logic [2:0] ACT_TERMINATE = 3'd2;
	localparam logic [2:0] ACT_BLOCK     = 3'd3;
	localparam logic [2:0] ACT_RESUME    = 3'd4;
	localparam logic [2:0] ACT_SLEEP     = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FREE   = 3'd1;
	localparam logic [2:0] ST_NO_THREAD = 3'd2;
	localparam logic [2:0] ST_REFUSED   = 3'd3;
	localparam logic [2:0] ST_MAIN_TERM = 3'd4;

	localparam logic [1:0] MODE_READY   = 2'd0;
	localparam logic [1:0] MODE_RUNNING = 2'd1;
	localparam logic [1:0] MODE_BLOCKED = 2'd2;

	localparam logic [31:0] QUANTA_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  thread_index;
		logic [15:0] sleep_quantums;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  spawned_id;
		logic [3:0]  running_now;
		logic [31:0] total_quanta;
		logic [31:0] target_quanta;
	} res_t;

	typedef struct packed {
		logic push;
		logic remove;
	} q_op_t;

endpackage

`default_nettype wire

[hdl/round_robin_thread_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Round-robin scheduler over MAX_THREADS slots with a FIFO ready queue.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req) is taken on a clock edge with start high and busy low.
//   busy stays high while a small sequencer works it; one result appears on
//   result with done high for exactly one cycle, and busy drops in that same
//   cycle. The receiver cannot stall; a new request may start in the done
//   cycle. quantum_length is written with quantum_length_we; the user must
//   write it only while idle, as the block itself does not enforce this.
// Work per request:
//   spawn: free-slot search, one slot a cycle
//   tick with expiry: sleep counter walk, requeue, dispatch
//   block/terminate of a queued thread: queue search, one entry a cycle
//   block/terminate/sleep of the running thread: dispatch
// Reset: slot 0 runs with one quantum counted, queue empty, quantum 100.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler #(
	parameter int MAX_THREADS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire  rrts_pkg::req_t req,
	output logic                 busy,
	output logic                 done,
	output rrts_pkg::res_t       result,
	input  wire                  quantum_length_we,
	input  wire  [15:0]          quantum_length
);

	localparam int IDW = $clog2(MAX_THREADS);
	localparam int CW  = $clog2(MAX_THREADS + 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_WAKE     = 8'b0000_0010,
		S_PUSHCUR  = 8'b0000_0100,
		S_DISPATCH = 8'b0000_1000,
		S_FIND     = 8'b0001_0000,
		S_SPAWN    = 8'b0010_0000,
		S_FREE     = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [IDW-1:0]  i_q;
	logic [3:0]      tid_q;
	logic [2:0]      status_q;
	logic [IDW-1:0]  spawned_q;
	logic            free_q;
	logic [15:0]     tick_q;
	logic [15:0]     ql_q;
	logic [IDW-1:0]  cur_q;
	logic [31:0]     total_q;
	logic            used_q   [MAX_THREADS];
	logic [1:0]      mode_q   [MAX_THREADS];
	logic [15:0]     sleep_q  [MAX_THREADS];
	logic [31:0]     quanta_q [MAX_THREADS];
	logic            done_q;
	rrts_pkg::res_t  res_q;

	rrts_pkg::q_op_t q_op;
	logic [IDW-1:0]  q_push_id;
	logic [IDW-1:0]  q_rm_pos;
	logic [IDW-1:0]  q_rd_id;
	logic [IDW-1:0]  q_front;
	logic [CW-1:0]   q_count;

	logic            accept;
	logic [IDW-1:0]  in_tix;
	logic            in_valid;
	logic [IDW-1:0]  tix_q;
	logic            tid_valid_q;
	logic            find_hit;
	logic            find_last;
	logic            wake_hit;
	logic            i_last;
	logic [IDW-1:0]  nxt;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign in_tix    = IDW'(req.thread_index);
	assign in_valid  = 32'(req.thread_index) < 32'(MAX_THREADS);
	assign tix_q     = IDW'(tid_q);
	assign tid_valid_q = 32'(tid_q) < 32'(MAX_THREADS);
	assign i_last    = (i_q == IDW'(MAX_THREADS - 1));
	assign find_hit  = (CW'(i_q) < q_count) && (q_rd_id == tix_q);
	assign find_last = (CW'(i_q) + CW'(1) >= q_count);
	assign wake_hit  = used_q[i_q] && (sleep_q[i_q] == 16'd1);
	assign nxt       = q_front;

	rrts_queue #(
		.MAX_THREADS(MAX_THREADS)
	) u_queue (
		.op       (q_op),
		.clk      (clk),
		.arst_n   (arst_n),
		.push_id  (q_push_id),
		.rm_pos   (q_rm_pos),
		.rd_pos   (i_q),
		.rd_id    (q_rd_id),
		.front_id (q_front),
		.count    (q_count)
	);

	always_comb begin
		q_op      = '0;
		q_push_id = i_q;
		q_rm_pos  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.action == rrts_pkg::ACT_RESUME && in_valid &&
					used_q[in_tix] && mode_q[in_tix] == rrts_pkg::MODE_BLOCKED &&
					sleep_q[in_tix] == 16'd0) begin
					q_op.push = 1'b1;
					q_push_id = in_tix;
				end
			end
			S_WAKE:     q_op.push = wake_hit;
			S_PUSHCUR: begin
				q_op.push = 1'b1;
				q_push_id = cur_q;
			end
			S_DISPATCH: q_op.remove = (q_count != '0);
			S_FIND: begin
				q_op.remove = find_hit;
				q_rm_pos    = i_q;
			end
			S_SPAWN:    q_op.push = !used_q[i_q];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			i_q       <= '0;
			tid_q     <= '0;
			status_q  <= rrts_pkg::ST_OK;
			spawned_q <= '0;
			free_q    <= 1'b0;
			tick_q    <= '0;
			ql_q      <= 16'd100;
			cur_q     <= '0;
			total_q   <= 32'd1;
			done_q    <= 1'b0;
			for (int k = 0; k < MAX_THREADS; k++) begin
				used_q[k]   <= (k == 0);
				mode_q[k]   <= (k == 0) ? rrts_pkg::MODE_RUNNING : rrts_pkg::MODE_READY;
				sleep_q[k]  <= '0;
				quanta_q[k] <= (k == 0) ? 32'd1 : 32'd0;
			end
		end else begin
			done_q <= (state_q == S_DONE);
			if (quantum_length_we) begin
				ql_q <= quantum_length;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						tid_q     <= req.thread_index;
						spawned_q <= '0;
						free_q    <= (req.action == rrts_pkg::ACT_TERMINATE);
						i_q       <= (req.action == rrts_pkg::ACT_SPAWN) ? IDW'(1) : '0;
						unique case (req.action) inside
							rrts_pkg::ACT_TICK: begin
								status_q <= rrts_pkg::ST_OK;
								if (17'(tick_q) + 17'd1 >= 17'(ql_q)) begin
									tick_q  <= '0;
									state_q <= S_WAKE;
								end else begin
									tick_q  <= tick_q + 16'd1;
									state_q <= S_DONE;
								end
							end
							rrts_pkg::ACT_SPAWN: begin
								status_q <= rrts_pkg::ST_NO_FREE;
								state_q  <= S_SPAWN;
							end
							rrts_pkg::ACT_TERMINATE, rrts_pkg::ACT_BLOCK: begin
								if (in_valid && in_tix == '0) begin
									status_q <= (req.action == rrts_pkg::ACT_TERMINATE) ?
										rrts_pkg::ST_MAIN_TERM : rrts_pkg::ST_REFUSED;
									state_q  <= S_DONE;
								end else if (!in_valid || !used_q[in_tix]) begin
									status_q <= rrts_pkg::ST_NO_THREAD;
									state_q  <= S_DONE;
								end else if (in_tix == cur_q) begin
									status_q <= rrts_pkg::ST_OK;
									tick_q   <= '0;
									state_q  <= S_DISPATCH;
									if (req.action == rrts_pkg::ACT_BLOCK) begin
										mode_q[in_tix] <= rrts_pkg::MODE_BLOCKED;
									end
								end else if (req.action == rrts_pkg::ACT_TERMINATE ||
									mode_q[in_tix] == rrts_pkg::MODE_READY) begin
									status_q <= rrts_pkg::ST_OK;
									state_q  <= S_FIND;
								end else begin
									status_q <= rrts_pkg::ST_OK;
									state_q  <= S_DONE;
								end
							end
							rrts_pkg::ACT_RESUME: begin
								state_q <= S_DONE;
								if (!in_valid || !used_q[in_tix]) begin
									status_q <= rrts_pkg::ST_NO_THREAD;
								end else begin
									status_q <= rrts_pkg::ST_OK;
									if (mode_q[in_tix] == rrts_pkg::MODE_BLOCKED &&
										sleep_q[in_tix] == 16'd0) begin
										mode_q[in_tix] <= rrts_pkg::MODE_READY;
									end
								end
							end
							rrts_pkg::ACT_SLEEP: begin
								if (cur_q == '0) begin
									status_q <= rrts_pkg::ST_REFUSED;
									state_q  <= S_DONE;
								end else begin
									status_q       <= rrts_pkg::ST_OK;
									sleep_q[cur_q] <= req.sleep_quantums;
									mode_q[cur_q]  <= rrts_pkg::MODE_BLOCKED;
									tick_q         <= '0;
									state_q        <= S_DISPATCH;
								end
							end
							default: begin
								status_q <= rrts_pkg::ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_WAKE: begin
					if (used_q[i_q] && sleep_q[i_q] != 16'd0) begin
						sleep_q[i_q] <= sleep_q[i_q] - 16'd1;
						if (wake_hit) begin
							mode_q[i_q] <= rrts_pkg::MODE_READY;
						end
					end
					i_q <= i_q + IDW'(1);
					if (i_last) begin
						state_q <= S_PUSHCUR;
					end
				end
				S_PUSHCUR: begin
					mode_q[cur_q] <= rrts_pkg::MODE_READY;
					state_q       <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (q_count != '0) begin
						cur_q        <= nxt;
						mode_q[nxt]  <= rrts_pkg::MODE_RUNNING;
						if (total_q != rrts_pkg::QUANTA_MAX) begin
							total_q <= total_q + 32'd1;
						end
						if (quanta_q[nxt] != rrts_pkg::QUANTA_MAX) begin
							quanta_q[nxt] <= quanta_q[nxt] + 32'd1;
						end
					end
					state_q <= free_q ? S_FREE : S_DONE;
				end
				S_FIND: begin
					i_q <= i_q + IDW'(1);
					if (find_hit || find_last) begin
						if (!free_q) begin
							mode_q[tix_q] <= rrts_pkg::MODE_BLOCKED;
						end
						state_q <= free_q ? S_FREE : S_DONE;
					end
				end
				S_SPAWN: begin
					i_q <= i_q + IDW'(1);
					if (!used_q[i_q]) begin
						used_q[i_q]   <= 1'b1;
						mode_q[i_q]   <= rrts_pkg::MODE_READY;
						sleep_q[i_q]  <= '0;
						quanta_q[i_q] <= '0;
						spawned_q     <= i_q;
						status_q      <= rrts_pkg::ST_OK;
						state_q       <= S_DONE;
					end else if (i_last) begin
						state_q <= S_DONE;
					end
				end
				S_FREE: begin
					used_q[tix_q]   <= 1'b0;
					mode_q[tix_q]   <= rrts_pkg::MODE_READY;
					sleep_q[tix_q]  <= '0;
					quanta_q[tix_q] <= '0;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			res_q.status        <= status_q;
			res_q.spawned_id    <= 4'(spawned_q);
			res_q.running_now   <= 4'(cur_q);
			res_q.total_quanta  <= total_q;
			res_q.target_quanta <= (tid_valid_q && used_q[tix_q]) ? quanta_q[tix_q] : 32'd0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");

	a_cur_used: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> used_q[cur_q]) else $error("running thread slot is free");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(MAX_THREADS)) else $error("ready queue count overflow");

endmodule

`default_nettype wire

[hdl/rrts_queue.sv]
// ----------------------------------------------------------------------------
// rrts_queue
// Ready queue: append at the tail, remove at any position with compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_queue #(
	parameter int MAX_THREADS = 16,
	localparam int IDW = $clog2(MAX_THREADS),
	localparam int CW  = $clog2(MAX_THREADS + 1)
) (
	input  wire                rrts_pkg::q_op_t op,
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [IDW-1:0]     push_id,
	input  wire  [IDW-1:0]     rm_pos,
	input  wire  [IDW-1:0]     rd_pos,
	output logic [IDW-1:0]     rd_id,
	output logic [IDW-1:0]     front_id,
	output logic [CW-1:0]      count
);

	logic [IDW-1:0] fifo_q [MAX_THREADS];
	logic [CW-1:0]  count_q;

	assign count    = count_q;
	assign rd_id    = fifo_q[rd_pos];
	assign front_id = fifo_q[0];

	always_ff @(posedge clk) begin
		if (op.push && count_q < CW'(MAX_THREADS)) begin
			fifo_q[count_q[IDW-1:0]] <= push_id;
		end else if (op.remove) begin
			for (int j = 0; j < MAX_THREADS - 1; j++) begin
				if (IDW'(j) >= rm_pos) begin
					fifo_q[j] <= fifo_q[j + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.push) begin
			if (count_q < CW'(MAX_THREADS)) begin
				count_q <= count_q + CW'(1);
			end
		end else if (op.remove && count_q != '0) begin
			count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire
